// ===== sv/tkpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tkpc_pkg - shared types and constants of the two-key press classifier
// Event codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tkpc_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned EVENT_W    = 4;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [EVENT_W-1:0]    event_t;

  // register indexes
  localparam cfg_idx_t REG_LONG_PRESS   = 2'd0;
  localparam cfg_idx_t REG_COMBO_HOLD   = 2'd1;
  localparam cfg_idx_t REG_COMBO_WINDOW = 2'd2;
  localparam cfg_idx_t REG_COMBO_IGNORE = 2'd3;

  // register reset values
  localparam cfg_word_t LONG_PRESS_RST   = 32'd1000;
  localparam cfg_word_t COMBO_HOLD_RST   = 32'd5000;
  localparam cfg_word_t COMBO_WINDOW_RST = 32'd300;
  localparam cfg_word_t COMBO_IGNORE_RST = 32'd500;

  // input command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // key select / level codes
  localparam logic KEY_ONE     = 1'b0;
  localparam logic KEY_TWO     = 1'b1;
  localparam logic LVL_PRESSED = 1'b0;

  // event codes
  localparam event_t EV_NONE        = 4'd0;
  localparam event_t EV_K1_PRESS    = 4'd1;
  localparam event_t EV_K1_SHORT    = 4'd2;
  localparam event_t EV_K1_LONG     = 4'd3;
  localparam event_t EV_K2_PRESS    = 4'd4;
  localparam event_t EV_K2_RELEASE  = 4'd5;
  localparam event_t EV_COMBO_START = 4'd6;
  localparam event_t EV_COMBO_HOLD  = 4'd7;
  localparam event_t EV_COMBO_END   = 4'd8;

endpackage

// ===== sv/tkpc_if.sv =====
// ----------------------------------------------------------------------------
// tkpc_if - valid/ready channels of the two-key press classifier
// Input channel carries key reports and ticks, output channel carries events.
// ----------------------------------------------------------------------------
interface tkpc_in_if;
  logic valid;
  logic ready;
  logic command;
  logic key_select;
  logic key_level;

  modport source (output valid, command, key_select, key_level, input ready);
  modport sink   (input valid, command, key_select, key_level, output ready);
endinterface

interface tkpc_out_if import tkpc_pkg::*; ;
  logic   valid;
  logic   ready;
  event_t event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

// ===== sv/two_key_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// two_key_press_classifier_core - key press / release and combo classifier
// Turns ticks and debounced key levels into one event code per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sink of beats {command, key_select, key_level}. command = tick
//            advances the time base and runs the combo check; otherwise the
//            beat is a level report for the selected key (0 = pressed).
//   out_ch : source of one event_code per input beat, in order.
//   cfg_*  : write-only register port, taken whenever cfg_we is high; the user
//            must write it only while the block is idle; the block does not enforce this.
// Path    : an accepted input beat passes the input register, then the classify
//           logic into the output register, before its event shows on out_ch.
// Rate    : 1 beat per cycle sustained while out_ch is ready; the per-beat work is a
//           handful of TIME_BITS subtract/compares on the state registers.
// Reset   : rst_n (sync, low) clears time base, key and combo state, empties
//           both registers and loads the register reset values.
// Stall   : a held output keeps its event; the input register still fills,
//           and in_ch.ready drops only when both stages are occupied.
// ----------------------------------------------------------------------------
module two_key_press_classifier_core import tkpc_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  tkpc_in_if.sink           in_ch,
  tkpc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  cfg_word_t         cfg_data
);

  // compare width: time differences against 32-bit thresholds
  localparam int unsigned CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  // configuration registers
  cfg_word_t long_press_r, combo_hold_r, combo_window_r, combo_ignore_r;

  // input stage
  logic in_valid_r;
  logic command_r, key_select_r, key_level_r;

  // output stage
  logic   out_valid_r;
  event_t event_r;

  // classifier state
  time_t now_r, now_nxt;
  logic  k1_down_r, k1_down_nxt;
  logic  k2_down_r, k2_down_nxt;
  time_t k1_stamp_r, k1_stamp_nxt;
  time_t k2_stamp_r, k2_stamp_nxt;
  logic  combo_active_r, combo_active_nxt;
  logic  combo_fired_r, combo_fired_nxt;
  time_t combo_start_r, combo_start_nxt;
  time_t combo_end_r, combo_end_nxt;
  event_t event_nxt;

  logic advance;
  logic in_take;

  // intermediate values
  time_t now_inc;
  time_t press_diff;
  time_t hold_elapsed;
  time_t k1_elapsed;
  time_t end_elapsed;
  logic  in_window;
  logic  hold_reached;
  logic  k1_long;
  logic  release_ok;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.event_code = event_r;

  // ---- arithmetic shared by the decode below ----
  assign now_inc      = now_r + time_t'(1);
  assign press_diff   = (k1_stamp_r > k2_stamp_r) ? (k1_stamp_r - k2_stamp_r)
                                                  : (k2_stamp_r - k1_stamp_r);
  assign hold_elapsed = now_inc - combo_start_r;      // tick checks at new time
  assign k1_elapsed   = now_r - k1_stamp_r;
  assign end_elapsed  = now_r - combo_end_r;

  assign in_window    = cmp_t'(press_diff)   <= cmp_t'(combo_window_r);
  assign hold_reached = cmp_t'(hold_elapsed) >= cmp_t'(combo_hold_r);
  assign k1_long      = cmp_t'(k1_elapsed)   >= cmp_t'(long_press_r);
  assign release_ok   = !combo_active_r && (cmp_t'(end_elapsed) > cmp_t'(combo_ignore_r));

  // ---- classify one beat ----
  always_comb begin
    now_nxt          = now_r;
    k1_down_nxt      = k1_down_r;
    k2_down_nxt      = k2_down_r;
    k1_stamp_nxt     = k1_stamp_r;
    k2_stamp_nxt     = k2_stamp_r;
    combo_active_nxt = combo_active_r;
    combo_fired_nxt  = combo_fired_r;
    combo_start_nxt  = combo_start_r;
    combo_end_nxt    = combo_end_r;
    event_nxt        = EV_NONE;

    unique case ({command_r, key_select_r}) inside
      {CMD_TICK, KEY_ONE}, {CMD_TICK, KEY_TWO}: begin
        now_nxt = now_inc;
        if (k1_down_r && k2_down_r) begin
          if (in_window) begin
            if (!combo_active_r) begin
              combo_active_nxt = 1'b1;
              combo_fired_nxt  = 1'b0;
              combo_start_nxt  = now_inc;
              event_nxt        = EV_COMBO_START;
            end else if (!combo_fired_r && hold_reached) begin
              combo_fired_nxt = 1'b1;
              event_nxt       = EV_COMBO_HOLD;
            end
          end
        end else if (combo_active_r) begin
          combo_active_nxt = 1'b0;
          combo_fired_nxt  = 1'b0;
          combo_end_nxt    = now_inc;
          event_nxt        = EV_COMBO_END;
        end
      end
      {CMD_KEY, KEY_ONE}: begin
        if (key_level_r == LVL_PRESSED) begin
          // repeated press while down is ignored
          if (!k1_down_r) begin
            k1_down_nxt  = 1'b1;
            k1_stamp_nxt = now_r;
            if (!combo_active_r) event_nxt = EV_K1_PRESS;
          end
        end else begin
          if (k1_down_r && release_ok) event_nxt = k1_long ? EV_K1_LONG : EV_K1_SHORT;
          k1_down_nxt = 1'b0;
        end
      end
      {CMD_KEY, KEY_TWO}: begin
        if (key_level_r == LVL_PRESSED) begin
          // key 2 restamps on every press
          k2_down_nxt  = 1'b1;
          k2_stamp_nxt = now_r;
          if (!combo_active_r) event_nxt = EV_K2_PRESS;
        end else begin
          if (release_ok) event_nxt = EV_K2_RELEASE;
          k2_down_nxt = 1'b0;
        end
      end
      default: event_nxt = EV_NONE;
    endcase
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LONG_PRESS_RST;
      combo_hold_r   <= COMBO_HOLD_RST;
      combo_window_r <= COMBO_WINDOW_RST;
      combo_ignore_r <= COMBO_IGNORE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   long_press_r   <= cfg_data;
        REG_COMBO_HOLD:   combo_hold_r   <= cfg_data;
        REG_COMBO_WINDOW: combo_window_r <= cfg_data;
        REG_COMBO_IGNORE: combo_ignore_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      command_r    <= in_ch.command;
      key_select_r <= in_ch.key_select;
      key_level_r  <= in_ch.key_level;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_r <= event_nxt;
    end
  end

  // ---- classifier state, updated once per classified beat ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      k1_down_r      <= 1'b0;
      k2_down_r      <= 1'b0;
      k1_stamp_r     <= '0;
      k2_stamp_r     <= '0;
      combo_active_r <= 1'b0;
      combo_fired_r  <= 1'b0;
      combo_start_r  <= '0;
      combo_end_r    <= '0;
    end else if (advance) begin
      now_r          <= now_nxt;
      k1_down_r      <= k1_down_nxt;
      k2_down_r      <= k2_down_nxt;
      k1_stamp_r     <= k1_stamp_nxt;
      k2_stamp_r     <= k2_stamp_nxt;
      combo_active_r <= combo_active_nxt;
      combo_fired_r  <= combo_fired_nxt;
      combo_start_r  <= combo_start_nxt;
      combo_end_r    <= combo_end_nxt;
    end
  end

endmodule

// ===== sim/two_key_press_classifier_core_test.sv =====
// ----------------------------------------------------------------------------
// two_key_press_classifier_core_test - self-checking bench for the classifier
// A table of directed beats runs first, then random key and tick traffic under
// several register settings. A predictor mirrors the key and combo state.
// Every event out of the block is checked in order against the table or that prediction.
// ----------------------------------------------------------------------------
module two_key_press_classifier_core_test;
  import tkpc_pkg::*;

  localparam int CLK_PERIOD         = 20;
  localparam int unsigned GAP_MAX   = 17;   // longest idle / stall per beat
  localparam int unsigned NUM_PHASES  = 8;  // register settings, one per phase
  localparam int unsigned PHASE_BEATS = 105;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned NUM_ROWS    = 31;

  // level code for a released key; the package only names the pressed level
  localparam logic LVL_RELEASED = 1'b1;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  // one line of the directed table: either an input beat or a register write
  typedef struct {
    row_kind_t kind;
    logic      command;
    logic      key_select;
    logic      key_level;
    bit        typed;      // expected event written into the table by hand
    event_t    code;
    cfg_idx_t  index;
    cfg_word_t data;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_data;

  tkpc_in_if  in_ch ();
  tkpc_out_if out_ch ();

  two_key_press_classifier_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted state of the classifier, and its register shadow
  // --------------------------------------------------------------------------
  logic [31:0] tick_now;       // time base, counts accepted tick beats
  logic        k1_down;
  logic        k2_down;
  logic [31:0] k1_stamp;       // tick_now at the last key 1 press
  logic [31:0] k2_stamp;
  logic        combo_on;
  logic        hold_sent;      // combo hold already reported for this combo
  logic [31:0] combo_t0;       // combo start time
  logic [31:0] combo_t1;       // last combo end time

  cfg_word_t long_thr;
  cfg_word_t hold_thr;
  cfg_word_t window_thr;
  cfg_word_t ignore_thr;

  event_t      pending_events [$];   // events still owed by the block, oldest first
  int unsigned error_count    = 0;
  int unsigned beats_sent     = 0;
  int unsigned events_checked = 0;
  int unsigned code_seen [0:EV_COMBO_END];

  int unsigned in_gap_max    = GAP_MAX;
  int unsigned out_stall_max = GAP_MAX;

  // a release is reported only outside a combo and once the quiet time after
  // the last combo end has fully run out (strictly greater than the setting)
  function automatic logic release_open();
    return !combo_on && ((tick_now - combo_t1) > ignore_thr);
  endfunction

  // advances the predicted state by one beat and returns the event it causes
  function automatic event_t classify_beat(logic cmd, logic sel, logic lvl);
    logic [31:0] spread;
    event_t      ev;
    ev = EV_NONE;
    if (cmd == CMD_TICK) begin
      tick_now = tick_now + 32'd1;
      if (k1_down && k2_down) begin
        // plain distance between the press stamps, no wrap handling
        spread = (k1_stamp > k2_stamp) ? k1_stamp - k2_stamp : k2_stamp - k1_stamp;
        if (spread <= window_thr) begin
          if (!combo_on) begin
            combo_on  = 1'b1;
            hold_sent = 1'b0;
            combo_t0  = tick_now;
            ev        = EV_COMBO_START;
          end else if (!hold_sent && ((tick_now - combo_t0) >= hold_thr)) begin
            hold_sent = 1'b1;
            ev        = EV_COMBO_HOLD;
          end
        end
        // both down but too far apart: nothing, a running combo stays on
      end else if (combo_on) begin
        combo_on  = 1'b0;
        hold_sent = 1'b0;
        combo_t1  = tick_now;
        ev        = EV_COMBO_END;
      end
    end else if (sel == KEY_ONE) begin
      if (lvl == LVL_PRESSED) begin
        // a second press while already down is dropped without a restamp
        if (!k1_down) begin
          k1_down  = 1'b1;
          k1_stamp = tick_now;
          if (!combo_on) ev = EV_K1_PRESS;
        end
      end else begin
        if (k1_down && release_open())
          ev = ((tick_now - k1_stamp) >= long_thr) ? EV_K1_LONG : EV_K1_SHORT;
        k1_down = 1'b0;
      end
    end else begin
      // key 2 restamps on every press and reports releases even while up
      if (lvl == LVL_PRESSED) begin
        k2_down  = 1'b1;
        k2_stamp = tick_now;
        if (!combo_on) ev = EV_K2_PRESS;
      end else begin
        if (release_open()) ev = EV_K2_RELEASE;
        k2_down = 1'b0;
      end
    end
    return ev;
  endfunction

  function automatic stim_row_t beat_row(logic cmd, logic sel, logic lvl,
                                         bit typed = 1'b0, event_t code = EV_NONE);
    stim_row_t row;
    row.kind       = ROW_BEAT;
    row.command    = cmd;
    row.key_select = sel;
    row.key_level  = lvl;
    row.typed      = typed;
    row.code       = code;
    row.index      = REG_LONG_PRESS;
    row.data       = '0;
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_t idx, cfg_word_t value);
    stim_row_t row;
    row       = beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED);
    row.kind  = ROW_REG;
    row.index = idx;
    row.data  = value;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // valid is left high after acceptance so back-to-back beats never lower and
  // raise it in one step; a gap or a drain lowers it.
  task automatic send_beat(input logic cmd, input logic sel, input logic lvl,
                           input bit typed, input event_t code);
    int unsigned gap;
    event_t      predicted;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.key_select <= sel;
    in_ch.key_level  <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    predicted = classify_beat(cmd, sel, lvl);
    pending_events.push_back(typed ? code : predicted);
    beats_sent++;
  endtask

  // hold the input off until every owed event has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // block must be idle; the spare edge keeps cfg_we from toggling in one step
  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LONG_PRESS:   long_thr   = value;
      REG_COMBO_HOLD:   hold_thr   = value;
      REG_COMBO_WINDOW: window_thr = value;
      REG_COMBO_IGNORE: ignore_thr = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random traffic. Key beats mostly toggle the key's predicted level so that
  // press/release pairs and combos really happen; the rest are repeats and
  // stray levels. Tick bursts let hold times and long presses mature.
  task automatic run_phase(input int unsigned n_beats);
    int unsigned done;
    int unsigned burst;
    int unsigned pick;
    bit          drained;
    logic        sel;
    logic        lvl;
    logic        held;
    done    = 0;
    drained = 1'b0;
    while (done < n_beats) begin
      if (!drained && done >= n_beats / 2) begin
        // stop mid-phase and let the pipeline run dry once
        settle();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        burst = $urandom_range(2, 12);
        repeat (burst)
          send_beat(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'b0, EV_NONE);
        done += burst;
      end else if (pick < 50) begin
        // select and level bits of a tick are don't-care; keep them moving
        send_beat(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'b0, EV_NONE);
        done++;
      end else begin
        sel  = 1'($urandom_range(0, 1));
        held = (sel == KEY_ONE) ? k1_down : k2_down;
        if ($urandom_range(0, 5) == 0)
          lvl = 1'($urandom_range(0, 1));
        else
          lvl = held ? LVL_RELEASED : LVL_PRESSED;
        send_beat(CMD_KEY, sel, lvl, 1'b0, EV_NONE);
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready drops for a random stall before each event
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // every accepted event is matched against the oldest owed one
  always @(posedge clk) begin
    event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event %0d with none expected", $time, out_ch.event_code);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_code !== want) begin
          $display("%0t: event_code mismatch, expected %0d, actual %0d",
                   $time, want, out_ch.event_code);
          error_count++;
        end
        events_checked++;
        if (out_ch.event_code <= EV_COMBO_END) code_seen[out_ch.event_code]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t   directed_rows [NUM_ROWS];
    int unsigned ph;
    int unsigned drain_wait;
    cfg_word_t   next_long;
    cfg_word_t   next_hold;
    cfg_word_t   next_window;
    cfg_word_t   next_ignore;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_KEY;
    in_ch.key_select <= KEY_ONE;
    in_ch.key_level  <= LVL_PRESSED;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_LONG_PRESS;
    cfg_data         <= '0;

    foreach (code_seen[i]) code_seen[i] = 0;

    // predictor starts from the reset state
    tick_now   = '0;
    k1_down    = 1'b0;
    k2_down    = 1'b0;
    k1_stamp   = '0;
    k2_stamp   = '0;
    combo_on   = 1'b0;
    hold_sent  = 1'b0;
    combo_t0   = '0;
    combo_t1   = '0;
    long_thr   = LONG_PRESS_RST;
    hold_thr   = COMBO_HOLD_RST;
    window_thr = COMBO_WINDOW_RST;
    ignore_thr = COMBO_IGNORE_RST;

    // First block runs on reset register values: hand-written expectations.
    // After the writes, short thresholds make hold, long press and the window
    // edge reachable in a few ticks; those rows go through the predictor.
    directed_rows = '{
      // releases straight after reset fall inside the quiet time
      beat_row(CMD_KEY,  KEY_ONE, LVL_RELEASED, 1'b1, EV_NONE),
      beat_row(CMD_KEY,  KEY_TWO, LVL_RELEASED, 1'b1, EV_NONE),
      beat_row(CMD_KEY,  KEY_ONE, LVL_PRESSED,  1'b1, EV_K1_PRESS),
      beat_row(CMD_KEY,  KEY_ONE, LVL_PRESSED,  1'b1, EV_NONE),      // repeat, dropped
      beat_row(CMD_KEY,  KEY_TWO, LVL_PRESSED,  1'b1, EV_K2_PRESS),
      beat_row(CMD_KEY,  KEY_TWO, LVL_PRESSED,  1'b1, EV_K2_PRESS),  // repeat, restamped
      beat_row(CMD_TICK, KEY_TWO, LVL_RELEASED, 1'b1, EV_COMBO_START),
      beat_row(CMD_KEY,  KEY_TWO, LVL_PRESSED,  1'b1, EV_NONE),      // muted in combo
      beat_row(CMD_KEY,  KEY_ONE, LVL_RELEASED, 1'b1, EV_NONE),      // muted in combo
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED,  1'b1, EV_COMBO_END),
      reg_row(REG_LONG_PRESS,   32'd3),
      reg_row(REG_COMBO_HOLD,   32'd1),
      reg_row(REG_COMBO_WINDOW, 32'd1),
      reg_row(REG_COMBO_IGNORE, 32'd0),
      beat_row(CMD_KEY,  KEY_TWO, LVL_RELEASED),  // same tick as combo end
      beat_row(CMD_KEY,  KEY_ONE, LVL_PRESSED),
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),
      beat_row(CMD_KEY,  KEY_TWO, LVL_PRESSED),   // one tick apart: in window
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),   // combo start
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),   // combo hold
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),   // hold fires only once
      beat_row(CMD_KEY,  KEY_TWO, LVL_RELEASED),
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),   // combo end
      beat_row(CMD_KEY,  KEY_ONE, LVL_RELEASED),
      beat_row(CMD_KEY,  KEY_ONE, LVL_PRESSED),
      beat_row(CMD_TICK, KEY_TWO, LVL_RELEASED),
      beat_row(CMD_TICK, KEY_TWO, LVL_RELEASED),
      beat_row(CMD_KEY,  KEY_TWO, LVL_PRESSED),   // two ticks apart: outside
      beat_row(CMD_TICK, KEY_ONE, LVL_PRESSED),   // both down, no combo
      beat_row(CMD_KEY,  KEY_ONE, LVL_RELEASED),  // long release
      beat_row(CMD_KEY,  KEY_TWO, LVL_RELEASED)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_beat(directed_rows[i].command, directed_rows[i].key_select,
                  directed_rows[i].key_level, directed_rows[i].typed,
                  directed_rows[i].code);
      end
    end

    // Random phases. The first three pin the registers to their extremes:
    // all zero, then all-ones thresholds with no quiet time, then every
    // release muted for good. The rest draw short values so that combos,
    // holds and long presses all come round often.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          next_long = '0; next_hold = '0; next_window = '0; next_ignore = '0;
        end
        1: begin
          next_long = '1; next_hold = '1; next_window = '1; next_ignore = '0;
        end
        2: begin
          next_long = '0; next_hold = 32'd1; next_window = '1; next_ignore = '1;
        end
        default: begin
          next_long   = $urandom_range(0, 12);
          next_hold   = $urandom_range(0, 30);
          next_window = $urandom_range(0, 6);
          next_ignore = $urandom_range(0, 15);
        end
      endcase
      settle();
      write_reg(REG_LONG_PRESS,   next_long);
      write_reg(REG_COMBO_HOLD,   next_hold);
      write_reg(REG_COMBO_WINDOW, next_window);
      write_reg(REG_COMBO_IGNORE, next_ignore);
      // one phase at full rate on both sides, one with the sink never stalling
      in_gap_max    = (ph == 3) ? 0 : GAP_MAX;
      out_stall_max = (ph == 3 || ph == 5) ? 0 : GAP_MAX;
      run_phase(PHASE_BEATS);
    end

    // drain, then give the two-stage pipeline a few spare edges
    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_events.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d events never arrived", $time, pending_events.size());
      error_count++;
    end

    $display("Sent %0d beats under %0d register settings, checked %0d events.",
             beats_sent, NUM_PHASES + 2, events_checked);
    $display("Combos started/held/ended: %0d/%0d/%0d, key 1 short/long: %0d/%0d.",
             code_seen[EV_COMBO_START], code_seen[EV_COMBO_HOLD],
             code_seen[EV_COMBO_END], code_seen[EV_K1_SHORT], code_seen[EV_K1_LONG]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("%0t: timed out", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
